@@ rtl/pvm_pkg.sv @@
// Package for the PCM voice mixer: payload types, constants, tables.
package pvm_pkg;

	localparam int PCM_VOICES = 12;
	localparam int ROM_BANKS = 16;
	localparam int BANK_BYTES = 65536;
	localparam int ALL_VOICES = 13;
	localparam int ADPCM_VOICE = 12;
	localparam int STORE_BYTES = ROM_BANKS * BANK_BYTES;
	localparam int STORE_AW = 20;
	localparam logic [31:0] ADPCM_RATE = 32'h0000_2aa0;

	localparam logic [1:0] FUNC_REG  = 2'd0;
	localparam logic [1:0] FUNC_MEM  = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;
	localparam logic [1:0] FUNC_MODE = 2'd3;

	localparam logic [2:0] SLOT_POS   = 3'd0;
	localparam logic [2:0] SLOT_STEP  = 3'd1;
	localparam logic [2:0] SLOT_LEND  = 3'd2;
	localparam logic [2:0] SLOT_LSTRT = 3'd3;
	localparam logic [2:0] SLOT_BANK  = 3'd4;
	localparam logic [2:0] SLOT_RGAIN = 3'd5;
	localparam logic [2:0] SLOT_LGAIN = 3'd6;

	localparam logic [7:0] A_ADPCM_END  = 8'h6d;
	localparam logic [7:0] A_ADPCM_RG0  = 8'h6e;
	localparam logic [7:0] A_ADPCM_BANK = 8'h6f;
	localparam logic [7:0] A_ADPCM_LG0  = 8'h70;
	localparam logic [7:0] A_ADPCM_RG1  = 8'h74;
	localparam logic [7:0] A_ADPCM_POS  = 8'h75;
	localparam logic [7:0] A_ADPCM_LG1  = 8'h78;

	localparam logic [0:0] CFG_MUTE  = 1'd0;
	localparam logic [0:0] CFG_BANKS = 1'd1;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  reg_address;
		logic [15:0] value;
		logic [19:0] rom_address;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] left_sample;
		logic signed [15:0] right_sample;
	} out_item_t;

	function automatic logic [7:0] layout_base(input logic [2:0] mode, input logic [2:0] slot);
		logic [7:0] r;
		r = 8'h00;
		unique case (mode)
			3'd0: case (slot)
				3'd1: r = 8'h18; 3'd2: r = 8'h24; 3'd3: r = 8'h30;
				3'd4: r = 8'h3c; 3'd5: r = 8'h48; 3'd6: r = 8'hff; default: r = 8'h00;
			endcase
			3'd1: case (slot)
				3'd1: r = 8'h16; 3'd2: r = 8'h21; 3'd3: r = 8'h2c;
				3'd4: r = 8'h37; 3'd5: r = 8'h42; 3'd6: r = 8'h4d; default: r = 8'h00;
			endcase
			3'd5: case (slot)
				3'd1: r = 8'h18; 3'd2: r = 8'h24; 3'd3: r = 8'h30;
				3'd4: r = 8'h3c; 3'd5: r = 8'h54; 3'd6: r = 8'h60; default: r = 8'h00;
			endcase
			3'd6: case (slot)
				3'd1: r = 8'h10; 3'd2: r = 8'h18; 3'd3: r = 8'h20;
				3'd4: r = 8'h28; 3'd5: r = 8'h38; 3'd6: r = 8'h40; default: r = 8'h00;
			endcase
			3'd7: case (slot)
				3'd1: r = 8'h12; 3'd2: r = 8'h1b; 3'd3: r = 8'h24;
				3'd4: r = 8'h2d; 3'd5: r = 8'h3f; 3'd6: r = 8'h48; default: r = 8'h00;
			endcase
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] step_scale(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0, 4'd1, 4'd15: r = 8'd154;
			4'd2, 4'd14: r = 8'd128;
			4'd3, 4'd13: r = 8'd102;
			4'd4, 4'd12: r = 8'd77;
			default: r = 8'd58;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/pvm_front.sv @@
// Front end: input handshake, transaction queue toward the voice engine.
module pvm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pvm_pkg::in_item_t in_data,
	output logic              q_valid,
	input  logic              q_ready,
	output pvm_pkg::in_item_t q_data
);
	import pvm_pkg::*;

	in_item_t  mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic push, pop;

	assign in_ready = (cnt_q != 3'd4);
	assign q_valid  = (cnt_q != 3'd0);
	assign q_data   = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end
endmodule

@@ rtl/pvm_engine.sv @@
// Back end: register decode, sample memory, per-voice tick sequencer, ADPCM.
module pvm_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  pvm_pkg::in_item_t  q_data,
	input  logic [12:0]        mute_mask,
	input  logic [4:0]         loaded_banks,
	output logic               out_valid,
	input  logic               out_ready,
	output pvm_pkg::out_item_t out_data
);
	import pvm_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_ACC  = 3'd3;
	localparam logic [2:0] ST_AD1  = 3'd4;
	localparam logic [2:0] ST_AD2  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;
	localparam logic [2:0] ST_DEC  = 3'd7;

	logic [7:0]  store [STORE_BYTES];
	logic [7:0]  rd_q;
	logic [STORE_AW-1:0] raddr;

	logic [31:0] pos_q   [ALL_VOICES];
	logic [20:0] step_q  [ALL_VOICES];
	logic [15:0] lstrt_q [ALL_VOICES];
	logic [15:0] lend_q  [ALL_VOICES];
	logic [15:0] bank_q  [ALL_VOICES];
	logic [15:0] rg_q    [ALL_VOICES];
	logic [15:0] lg_q    [ALL_VOICES];
	logic signed [15:0] alvl_q;
	logic [10:0] astep_q;
	logic rgw_q, stereo_q, adon_q;
	logic [2:0] mode_q;
	logic [3:0] nv_q;

	logic [2:0]  st_q;
	logic [3:0]  v_q;
	logic signed [31:0] l_q, r_q;
	logic signed [33:0] pl_q, pr_q;
	logic [31:0] oldpos_q;
	logic [31:0] mstep_q;
	logic signed [15:0] lvl_new_q;
	logic [3:0]  nib_q;
	logic [4:0]  nbanks;

	// decode
	logic [2:0] slot;
	logic [7:0] vi;
	in_item_t d;
	assign d = q_data;
	always_comb begin
		slot = 3'd0;
		for (int s = 1; s < 7; s++)
			if (d.reg_address >= layout_base(mode_q, 3'(s))) slot = 3'(s);
		vi = d.reg_address - layout_base(mode_q, slot);
	end

	assign nbanks = (loaded_banks > 5'(ROM_BANKS)) ? 5'(ROM_BANKS) : loaded_banks;

	// voice gains and eligibility
	logic [15:0] cur_bank;
	logic signed [17:0] lvg, rvg;
	logic [15:0] rgs, lgs;
	logic elig;
	logic [3:0] nvc;
	assign nvc = (nv_q > 4'(PCM_VOICES)) ? 4'(PCM_VOICES) : nv_q;
	assign cur_bank = bank_q[v_q];
	always_comb begin
		rgs = rg_q[v_q];
		lgs = stereo_q ? lg_q[v_q] : rgs;
		if (stereo_q && !rgw_q) rgs = lgs;
		lvg = $signed({2'b0, lgs});
		rvg = $signed({2'b0, rgs});
		elig = !mute_mask[v_q] && (cur_bank < {11'b0, nbanks});
	end

	always_comb begin
		if (st_q == ST_IDLE && q_valid && d.func == FUNC_MEM)
			raddr = d.rom_address;
		else if (v_q == 4'(ADPCM_VOICE))
			raddr = {cur_bank[3:0], pos_q[v_q][31:16]};
		else
			raddr = {cur_bank[3:0], pos_q[v_q][31:16]};
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid && d.func == FUNC_MEM)
			store[raddr] <= d.value[7:0];
		rd_q <= store[raddr];
	end

	assign q_ready = (st_q == ST_IDLE) && !out_valid;

	logic signed [8:0] smp;
	assign smp = $signed({rd_q[7], rd_q});
	logic [31:0] npos, wpos;
	assign npos = pos_q[v_q] + {11'b0, step_q[v_q]};
	assign wpos = (npos >= {lend_q[v_q], 16'b0}) ?
		npos + {lstrt_q[v_q], 16'b0} - {lend_q[v_q], 16'b0} : npos;

	// ADPCM decode arithmetic from registered nibble
	logic signed [4:0] val;
	logic signed [16:0] t;
	logic signed [17:0] lsum;
	logic [18:0] sprod;
	logic [12:0] sshift;
	assign val = $signed({nib_q[3], nib_q});
	assign t = $signed({1'b0, astep_q}) * val + ((val > 0) ?
		$signed({6'b0, astep_q[10:1]}) : -$signed({6'b0, astep_q[10:1]}));
	assign lsum = alvl_q + t;
	assign sprod = astep_q * step_scale(4'(val + 5'sd8));
	assign sshift = sprod[18:6];

	logic signed [31:0] lsat, rsat;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; v_q <= '0; out_valid <= 1'b0;
			for (int i = 0; i < ALL_VOICES; i++) begin
				pos_q[i] <= '0; step_q[i] <= '0; lstrt_q[i] <= '0; lend_q[i] <= '0;
				bank_q[i] <= '0; rg_q[i] <= '0; lg_q[i] <= '0;
			end
			alvl_q <= '0; astep_q <= 11'd10; rgw_q <= 1'b0; mode_q <= 3'd1;
			nv_q <= 4'd12; stereo_q <= 1'b1; adon_q <= 1'b1;
			l_q <= '0; r_q <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid && q_ready) begin
					case (d.func)
						FUNC_REG: begin
							if (d.reg_address < A_ADPCM_END) begin
								if (vi < {4'b0, nvc}) begin
									case (slot)
										SLOT_POS:   pos_q[vi[3:0]] <= {d.value, 16'b0};
										SLOT_STEP:  step_q[vi[3:0]] <= {d.value, 5'b0};
										SLOT_LEND:  lend_q[vi[3:0]] <= d.value;
										SLOT_LSTRT: lstrt_q[vi[3:0]] <= d.value;
										SLOT_BANK:  bank_q[vi[3:0]] <= d.value;
										SLOT_RGAIN: begin rg_q[vi[3:0]] <= d.value; rgw_q <= 1'b1; end
										default:    lg_q[vi[3:0]] <= d.value;
									endcase
								end
							end else if (adon_q) begin
								case (d.reg_address)
									A_ADPCM_END:  lend_q[ADPCM_VOICE] <= d.value;
									A_ADPCM_BANK: bank_q[ADPCM_VOICE] <= d.value;
									A_ADPCM_RG0, A_ADPCM_RG1: begin
										rg_q[ADPCM_VOICE] <= d.value; rgw_q <= 1'b1;
									end
									A_ADPCM_POS: begin
										pos_q[ADPCM_VOICE] <= {d.value, 16'b0};
										alvl_q <= '0; astep_q <= 11'd10;
									end
									A_ADPCM_LG0, A_ADPCM_LG1: lg_q[ADPCM_VOICE] <= d.value;
									default: ;
								endcase
							end
						end
						FUNC_MODE: begin
							for (int i = 0; i < ALL_VOICES; i++) begin
								pos_q[i] <= '0; step_q[i] <= '0; lstrt_q[i] <= '0;
								lend_q[i] <= '0; bank_q[i] <= '0; rg_q[i] <= '0; lg_q[i] <= '0;
							end
							alvl_q <= '0; astep_q <= 11'd10;
							case (d.value[7:0])
								8'd0: begin stereo_q <= 1'b0; nv_q <= 4'd12; adon_q <= 1'b1; mode_q <= 3'd0; end
								8'd1: begin stereo_q <= 1'b1; nv_q <= 4'd11; adon_q <= 1'b1; mode_q <= 3'd1; end
								8'd5: begin stereo_q <= 1'b1; nv_q <= 4'd12; adon_q <= 1'b0; mode_q <= 3'd5; end
								8'd6: begin stereo_q <= 1'b1; nv_q <= 4'd8;  adon_q <= 1'b0; mode_q <= 3'd6; end
								8'd7: begin stereo_q <= 1'b1; nv_q <= 4'd9;  adon_q <= 1'b0; mode_q <= 3'd7; end
								default: ;
							endcase
						end
						FUNC_TICK: begin
							l_q <= '0; r_q <= '0;
							if (nbanks == 5'd0) st_q <= ST_FIN;
							else begin
								v_q <= 4'd0;
								st_q <= (nvc == 4'd0) ? ST_AD1 : ST_RD;
								if (nvc == 4'd0) v_q <= 4'(ADPCM_VOICE);
							end
						end
						default: ;
					endcase
				end
				ST_RD: begin
					// memory read of the current voice issued this cycle
					if (!elig) begin
						if (v_q + 4'd1 >= nvc) begin v_q <= 4'(ADPCM_VOICE); st_q <= ST_AD1; end
						else v_q <= v_q + 4'd1;
					end else st_q <= ST_MUL;
				end
				ST_MUL: begin
					pl_q <= 34'($signed({smp, 8'b0}) * lvg);
					pr_q <= 34'($signed({smp, 8'b0}) * rvg);
					pos_q[v_q] <= wpos;
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					l_q <= l_q + 32'(pl_q >>> 16);
					r_q <= r_q + 32'(pr_q >>> 16);
					if (v_q + 4'd1 >= nvc) begin v_q <= 4'(ADPCM_VOICE); st_q <= ST_AD1; end
					else begin v_q <= v_q + 4'd1; st_q <= ST_RD; end
				end
				ST_AD1: begin
					if (adon_q && elig && pos_q[v_q] < {lend_q[v_q], 16'b0}) begin
						pl_q <= 34'(alvl_q * $signed({lvg, 1'b0}));
						pr_q <= 34'(alvl_q * $signed({rvg, 1'b0}));
						oldpos_q <= pos_q[v_q];
						mstep_q <= pos_q[v_q] + ADPCM_RATE;
						pos_q[v_q] <= pos_q[v_q] + ADPCM_RATE;
						st_q <= ST_AD2;
					end else st_q <= ST_FIN;
				end
				ST_AD2: begin
					l_q <= l_q + 32'(pl_q >>> 16);
					r_q <= r_q + 32'(pr_q >>> 16);
					nib_q <= oldpos_q[15] ? rd_q[3:0] : rd_q[7:4];
					st_q <= ((oldpos_q[15] ^ mstep_q[15]) != 1'b0) ? ST_DEC : ST_FIN;
				end
				ST_DEC: begin
					alvl_q <= (lsum > 18'sd32767) ? 16'sd32767 :
						(lsum < -18'sd32768) ? -16'sd32768 : 16'(lsum);
					astep_q <= (sshift > 13'd2000) ? 11'd2000 :
						(sshift < 13'd1) ? 11'd1 : sshift[10:0];
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					out_data.left_sample <= (l_q > 32767) ? 16'sd32767 :
						(l_q < -32768) ? -16'sd32768 : 16'(l_q);
					out_data.right_sample <= (r_q > 32767) ? 16'sd32767 :
						(r_q < -32768) ? -16'sd32768 : 16'(r_q);
					out_valid <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	logic unused;
	assign unused = ^{lsat, rsat, lvl_new_q};
	assign lsat = '0;
	assign rsat = '0;
	assign lvl_new_q = '0;
endmodule

@@ rtl/pcm_voice_mixer_adpcm.sv @@
// Top level of the PCM voice mixer: configuration port, front end, engine.
// Register writes, sample byte writes and mode selects are queued by the front
// end and each is handled in the engine's idle state. A sample tick walks the
// active voices in turn through the sample memory read port: a read state only
// for a muted or missing-bank voice, read, multiply and accumulate for a sounding
// one, then the ADPCM states and a final state that forms the output. The tick
// result is held in an output register; a new transaction is taken once that
// result has been delivered. Config: 0x0 mute_mask, 0x4 loaded_banks.
module pcm_voice_mixer_adpcm (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pvm_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output pvm_pkg::out_item_t out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import pvm_pkg::*;

	logic [12:0] mute_q;
	logic [4:0]  banks_q;
	logic        qv, qr;
	in_item_t    qd;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mute_q <= '0; banks_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == CFG_BANKS) banks_q <= pwdata[4:0];
			else mute_q <= pwdata[12:0];
		end
	end
	always_comb begin
		prdata = '0;
		if (paddr[2] == CFG_MUTE) prdata = {19'b0, mute_q};
		else prdata = {27'b0, banks_q};
	end

	pvm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .q_valid(qv), .q_ready(qr), .q_data(qd)
	);

	pvm_engine u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_ready(qr), .q_data(qd),
		.mute_mask(mute_q), .loaded_banks(banks_q),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

@@ bench/testbench.sv @@
// Testbench for the PCM voice mixer: directed and random stimulus checked against a local model.
`timescale 1ns / 1ps

module testbench;
	import pvm_pkg::*;

	// ---------------------------------------------------------------
	// Clock, reset and block ports
	// ---------------------------------------------------------------
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_ready;
	out_item_t   out_data;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 60;

	pcm_voice_mixer_adpcm dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Mixer model state
	// ---------------------------------------------------------------
	logic [31:0] mdl_pos    [ALL_VOICES];
	logic [20:0] mdl_step   [ALL_VOICES];
	logic [15:0] mdl_lstart [ALL_VOICES];
	logic [15:0] mdl_lend   [ALL_VOICES];
	logic [15:0] mdl_bank   [ALL_VOICES];
	logic [15:0] mdl_rgain  [ALL_VOICES];
	logic [15:0] mdl_lgain  [ALL_VOICES];
	int          mdl_level;
	int          mdl_astep;
	bit          mdl_rg_written;
	logic [2:0]  mdl_layout;
	int          mdl_nvoices;
	bit          mdl_stereo;
	bit          mdl_adpcm_on;
	logic [12:0] mdl_mute;
	logic [4:0]  mdl_banks;
	logic [7:0]  rom_image [int];	// written bytes only

	out_item_t   expected_mix[$];
	int          error_count;
	int          tick_count;
	int          sent_count;
	int          idle_cycles;
	bit          sender_bursty;
	bit          hold_off_req;
	int          hold_off_len;

	// ---------------------------------------------------------------
	// Model helpers
	// ---------------------------------------------------------------
	function automatic longint shr16_floor(longint x);
		return x >>> 16;
	endfunction

	function automatic longint rom_sample(logic [15:0] bank, logic [15:0] idx);
		longint a;
		logic [7:0] b;
		a = longint'(bank) * BANK_BYTES + idx;
		b = 8'h00;
		if (a < STORE_BYTES && rom_image.exists(int'(a)))
			b = rom_image[int'(a)];
		return longint'($signed(b));
	endfunction

	function automatic void clear_voice_state();
		for (int v = 0; v < ALL_VOICES; v++) begin
			mdl_pos[v] = '0; mdl_step[v] = '0; mdl_lstart[v] = '0; mdl_lend[v] = '0;
			mdl_bank[v] = '0; mdl_rgain[v] = '0; mdl_lgain[v] = '0;
		end
		mdl_level = 0;
		mdl_astep = 10;
	endfunction

	function automatic void model_reset();
		mdl_mute = '0;
		mdl_banks = '0;
		clear_voice_state();
		mdl_rg_written = 1'b0;
		mdl_layout = 3'd1;
		mdl_nvoices = 12;
		mdl_stereo = 1'b1;
		mdl_adpcm_on = 1'b1;
		rom_image.delete();
	endfunction

	function automatic void model_mode(logic [7:0] m);
		clear_voice_state();
		case (m)
			8'd0: begin mdl_stereo = 0; mdl_nvoices = 12; mdl_adpcm_on = 1; mdl_layout = 3'd0; end
			8'd1: begin mdl_stereo = 1; mdl_nvoices = 11; mdl_adpcm_on = 1; mdl_layout = 3'd1; end
			8'd5: begin mdl_stereo = 1; mdl_nvoices = 12; mdl_adpcm_on = 0; mdl_layout = 3'd5; end
			8'd6: begin mdl_stereo = 1; mdl_nvoices = 8;  mdl_adpcm_on = 0; mdl_layout = 3'd6; end
			8'd7: begin mdl_stereo = 1; mdl_nvoices = 9;  mdl_adpcm_on = 0; mdl_layout = 3'd7; end
			default: ;
		endcase
	endfunction

	// Layout row of the current mode, mirrored from the chip's address map
	function automatic int layout_row(int slot);
		case (mdl_layout)
			3'd0: case (slot) 1: return 'h18; 2: return 'h24; 3: return 'h30;
				4: return 'h3c; 5: return 'h48; 6: return 'hff; default: return 0; endcase
			3'd1: case (slot) 1: return 'h16; 2: return 'h21; 3: return 'h2c;
				4: return 'h37; 5: return 'h42; 6: return 'h4d; default: return 0; endcase
			3'd5: case (slot) 1: return 'h18; 2: return 'h24; 3: return 'h30;
				4: return 'h3c; 5: return 'h54; 6: return 'h60; default: return 0; endcase
			3'd6: case (slot) 1: return 'h10; 2: return 'h18; 3: return 'h20;
				4: return 'h28; 5: return 'h38; 6: return 'h40; default: return 0; endcase
			3'd7: case (slot) 1: return 'h12; 2: return 'h1b; 3: return 'h24;
				4: return 'h2d; 5: return 'h3f; 6: return 'h48; default: return 0; endcase
			default: return 0;
		endcase
	endfunction

	function automatic void model_reg_write(logic [7:0] a, logic [15:0] d);
		int slot;
		int v;
		if (a < A_ADPCM_END) begin
			slot = 6;
			while (slot > 0 && int'(a) < layout_row(slot))
				slot--;
			v = int'(a) - layout_row(slot);
			if (v >= mdl_nvoices)
				return;
			case (slot)
				0: mdl_pos[v] = {d, 16'h0000};
				1: mdl_step[v] = {d, 5'b0};
				2: mdl_lend[v] = d;
				3: mdl_lstart[v] = d;
				4: mdl_bank[v] = d;
				5: begin mdl_rgain[v] = d; mdl_rg_written = 1'b1; end
				default: mdl_lgain[v] = d;
			endcase
		end else if (mdl_adpcm_on) begin
			case (a)
				A_ADPCM_END:  mdl_lend[ADPCM_VOICE] = d;
				A_ADPCM_BANK: mdl_bank[ADPCM_VOICE] = d;
				A_ADPCM_RG0, A_ADPCM_RG1: begin
					mdl_rgain[ADPCM_VOICE] = d;
					mdl_rg_written = 1'b1;
				end
				A_ADPCM_POS: begin
					mdl_pos[ADPCM_VOICE] = {d, 16'h0000};
					mdl_level = 0;
					mdl_astep = 10;
				end
				A_ADPCM_LG0, A_ADPCM_LG1: mdl_lgain[ADPCM_VOICE] = d;
				default: ;
			endcase
		end
	endfunction

	function automatic void voice_gains(int v, output longint lg, output longint rg);
		rg = mdl_rgain[v];
		lg = mdl_stereo ? longint'(mdl_lgain[v]) : rg;
		if (mdl_stereo && !mdl_rg_written)
			rg = lg;
	endfunction

	function automatic void adpcm_nibble(logic [31:0] oldpos);
		logic [7:0] b;
		logic [3:0] nib;
		int val;
		int t;
		b = 8'(rom_sample(mdl_bank[ADPCM_VOICE], oldpos[31:16]));
		nib = oldpos[15] ? b[3:0] : b[7:4];
		val = int'($signed(nib));
		t = mdl_astep * val;
		t += (val > 0) ? (mdl_astep >>> 1) : -(mdl_astep >>> 1);
		mdl_level += t;
		if (mdl_level > 32767) mdl_level = 32767;
		else if (mdl_level < -32768) mdl_level = -32768;
		mdl_astep = (mdl_astep * int'(step_scale(4'(val + 8)))) >>> 6;
		if (mdl_astep > 2000) mdl_astep = 2000;
		else if (mdl_astep < 1) mdl_astep = 1;
	endfunction

	function automatic out_item_t mix_tick();
		out_item_t res;
		int banks;
		longint l, r, lg, rg, s;
		logic [31:0] p, oldp;
		banks = (mdl_banks < ROM_BANKS) ? int'(mdl_banks) : ROM_BANKS;
		l = 0; r = 0;
		res = '0;
		if (banks == 0)
			return res;
		for (int v = 0; v < mdl_nvoices; v++) begin
			if (mdl_mute[v]) continue;
			if (int'(mdl_bank[v]) >= banks) continue;
			voice_gains(v, lg, rg);
			p = mdl_pos[v];
			s = rom_sample(mdl_bank[v], p[31:16]) * 256;
			l += shr16_floor(s * lg);
			r += shr16_floor(s * rg);
			p += 32'(mdl_step[v]);
			if (p >= {mdl_lend[v], 16'h0})
				p += {mdl_lstart[v], 16'h0} - {mdl_lend[v], 16'h0};
			mdl_pos[v] = p;
		end
		if (mdl_adpcm_on && !mdl_mute[ADPCM_VOICE] && int'(mdl_bank[ADPCM_VOICE]) < banks) begin
			p = mdl_pos[ADPCM_VOICE];
			if (p < {mdl_lend[ADPCM_VOICE], 16'h0}) begin
				oldp = p;
				voice_gains(ADPCM_VOICE, lg, rg);
				l += shr16_floor(longint'(mdl_level) * (lg * 2));
				r += shr16_floor(longint'(mdl_level) * (rg * 2));
				p += ADPCM_RATE;
				if ((oldp ^ p) & 32'h8000)
					adpcm_nibble(oldp);
				mdl_pos[ADPCM_VOICE] = p;
			end
		end
		res.left_sample  = (l > 32767) ? 16'sd32767 : ((l < -32768) ? -16'sd32768 : 16'(l));
		res.right_sample = (r > 32767) ? 16'sd32767 : ((r < -32768) ? -16'sd32768 : 16'(r));
		return res;
	endfunction

	function automatic void model_accept(in_item_t it);
		case (it.func)
			FUNC_REG:  model_reg_write(it.reg_address, it.value);
			FUNC_MEM:  if (it.rom_address < STORE_BYTES) rom_image[int'(it.rom_address)] = it.value[7:0];
			FUNC_MODE: model_mode(it.value[7:0]);
			default: begin
				expected_mix.push_back(mix_tick());
				tick_count++;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Reporting and checking
	// ---------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		error_count++;
		$display("%0t ERROR %s: got %0d, expected %0d", $realtime, what, got, want);
	endtask

	// Receiver: random stall pattern, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				for (int i = 0; i < hold_off_len; i++) @(negedge clk);
				hold_off_req = 1'b0;
			end
			case ($urandom_range(0, 3))
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	// Result checker, sampling at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_mix.size() == 0) begin
				report_mismatch("unexpected output transaction", 1, 0);
			end else begin
				out_item_t want;
				want = expected_mix.pop_front();
				if (out_data.left_sample !== want.left_sample)
					report_mismatch("left_sample", out_data.left_sample, want.left_sample);
				if (out_data.right_sample !== want.right_sample)
					report_mismatch("right_sample", out_data.right_sample, want.right_sample);
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired");
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Stimulus tasks
	// ---------------------------------------------------------------
	// Send one transaction; random gap first when running bursty
	task automatic send_item(in_item_t it);
		if (sender_bursty && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		model_accept(it);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic send_fields(logic [1:0] f, logic [7:0] a, logic [15:0] d, logic [19:0] ra);
		in_item_t it;
		it.func = f; it.reg_address = a; it.value = d; it.rom_address = ra;
		send_item(it);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_mix.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic cfg_write(logic [0:0] idx, logic [31:0] d);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == CFG_MUTE) mdl_mute = d[12:0];
		else mdl_banks = d[4:0];
	endtask

	task automatic configure(logic [12:0] mute, logic [4:0] banks);
		wait_idle();
		cfg_write(CFG_MUTE, 32'(mute));
		cfg_write(CFG_BANKS, 32'(banks));
	endtask

	// Write count sample bytes at random addresses anywhere in the sample store
	task automatic load_samples(int count);
		for (int i = 0; i < count; i++)
			send_fields(FUNC_MEM, 8'($urandom), 16'($urandom), 20'($urandom));
	endtask

	// Directed: extremes, every function, odd modes and addresses
	task automatic test_directed();
		sender_bursty = 1'b0;
		configure(13'h0000, 5'd0);
		send_fields(FUNC_TICK, 8'h00, 16'h0000, 20'h00000);	// no banks: silent
		configure(13'h0000, 5'd16);
		send_fields(FUNC_MEM, 8'hff, 16'hff80, 20'h00000);
		send_fields(FUNC_MEM, 8'h00, 16'h007f, 20'hfffff);
		send_fields(FUNC_REG, 8'h42, 16'hffff, 20'hfffff);	// right gain, voice 0
		send_fields(FUNC_REG, 8'h4d, 16'hffff, 20'h00000);	// left gain, voice 0
		send_fields(FUNC_REG, 8'h00, 16'h0000, 20'h00000);
		send_fields(FUNC_REG, 8'h16, 16'hffff, 20'h00000);	// max step
		send_fields(FUNC_REG, 8'h21, 16'h0001, 20'h00000);	// tiny loop end
		send_fields(FUNC_REG, 8'h6f, 16'h000f, 20'h00000);	// ADPCM on top bank
		send_fields(FUNC_REG, 8'h75, 16'hffff, 20'h00000);
		send_fields(FUNC_REG, 8'h6d, 16'hffff, 20'h00000);	// position at end: silent
		send_fields(FUNC_REG, 8'hff, 16'h1234, 20'h00000);	// unmapped
		send_fields(FUNC_REG, 8'h4c, 16'h5555, 20'h00000);	// right gain, voice 10
		send_fields(FUNC_TICK, 8'h00, 16'h0000, 20'h00000);
		send_fields(FUNC_TICK, 8'hff, 16'hffff, 20'hfffff);
		send_fields(FUNC_MODE, 8'h00, 16'h0002, 20'h00000);	// unknown mode: clear only
		send_fields(FUNC_MODE, 8'h00, 16'h0000, 20'h00000);	// mono
		send_fields(FUNC_REG, 8'h48, 16'h8000, 20'h00000);
		send_fields(FUNC_TICK, 8'h00, 16'h0000, 20'h00000);
		send_fields(FUNC_MODE, 8'h00, 16'hff05, 20'h00000);	// ADPCM off
		send_fields(FUNC_REG, 8'h75, 16'h0000, 20'h00000);	// ignored
		send_fields(FUNC_TICK, 8'h00, 16'h0000, 20'h00000);
		configure(13'h1fff, 5'd31);
		send_fields(FUNC_TICK, 8'h00, 16'h0000, 20'h00000);
	endtask

	// Random setup of one mode: voices, loops, gains, then a run of ticks
	task automatic run_scene(int ticks);
		logic [7:0] modes [5] = '{8'd0, 8'd1, 8'd5, 8'd6, 8'd7};
		int pick;
		send_fields(FUNC_MODE, 8'($urandom), {8'($urandom), modes[$urandom_range(0, 4)]}, 20'($urandom));
		for (int i = 0; i < 10; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 7)
				send_fields(FUNC_REG, 8'($urandom_range(0, 'h6c)), 16'($urandom), 20'($urandom));
			else if (pick < 9)
				send_fields(FUNC_REG, 8'($urandom_range('h6d, 'h78)),
					(pick == 7) ? 16'($urandom_range(0, 3)) : 16'($urandom), 20'($urandom));
			else
				send_fields(FUNC_REG, 8'($urandom_range('h79, 'hff)), 16'($urandom), 20'($urandom));
		end
		// Keep banks small so most voices sound
		for (int v = 0; v < 4; v++)
			send_fields(FUNC_REG, 8'(layout_row(4) + v), 16'($urandom_range(0, 3)), 20'($urandom));
		if (mdl_adpcm_on) begin
			send_fields(FUNC_REG, A_ADPCM_BANK, 16'($urandom_range(0, 2)), 20'($urandom));
			send_fields(FUNC_REG, A_ADPCM_END, 16'($urandom_range(1, 8)), 20'($urandom));
			send_fields(FUNC_REG, A_ADPCM_POS, 16'h0000, 20'($urandom));
		end
		for (int i = 0; i < ticks; i++) begin
			if ($urandom_range(0, 7) == 0)
				send_fields(FUNC_MEM, 8'($urandom), 16'($urandom), 20'($urandom_range(0, 'h2ffff)));
			else
				send_fields(FUNC_TICK, 8'($urandom), 16'($urandom), 20'($urandom));
		end
	endtask

	task automatic test_random();
		logic [4:0] bank_opts [4] = '{5'd1, 5'd3, 5'd16, 5'd20};
		sender_bursty = 1'b1;
		for (int sc = 0; sc < 20; sc++) begin
			if (sc % 5 == 0)
				configure(($urandom_range(0, 2) == 0) ? 13'($urandom) : 13'h0000,
					bank_opts[$urandom_range(0, 3)]);
			sender_bursty = (sc % 3 != 0);
			run_scene($urandom_range(8, 20));
		end
	endtask

	// Long receiver hold-off while items keep coming; then a drain and more ticks
	task automatic test_backpressure();
		sender_bursty = 1'b0;
		hold_off_len = 400;
		hold_off_req = 1'b1;
		for (int i = 0; i < 30; i++)
			send_fields(FUNC_TICK, 8'h00, 16'h0000, 20'h00000);
		in_valid <= 1'b0;
		while (expected_mix.size() != 0) @(negedge clk);
		for (int i = 0; i < 10; i++)
			send_fields(FUNC_TICK, 8'h00, 16'h0000, 20'h00000);
	endtask

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		error_count = 0; tick_count = 0; sent_count = 0; idle_cycles = 0;
		hold_off_req = 1'b0; hold_off_len = 0; sender_bursty = 1'b0;
		model_reset();
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		load_samples(40);
		test_directed();
		configure(13'h0000, 5'd4);
		for (int i = 0; i < 8; i++)
			send_fields(FUNC_MEM, 8'h00, 16'($urandom), 20'($urandom_range(0, 'h3ffff)));
		test_random();
		test_backpressure();
		configure(13'h0aaa, 5'd2);
		test_random();
		wait_idle();
		$display("Sent %0d transactions, %0d sample ticks checked across all modes,",
			sent_count, tick_count);
		$display("mute and bank settings, ADPCM decode and output backpressure.");
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
rtl/pvm_pkg.sv
rtl/pvm_front.sv
rtl/pvm_engine.sv
rtl/pcm_voice_mixer_adpcm.sv
bench/testbench.sv
